// ===== src/qtl_pkg.sv =====
`timescale 1ns / 1ps

package qtl_pkg;

    localparam logic [3:0] KIND_END    = 4'd0;
    localparam logic [3:0] KIND_COLON  = 4'd1;
    localparam logic [3:0] KIND_OPEN   = 4'd2;
    localparam logic [3:0] KIND_CLOSE  = 4'd3;
    localparam logic [3:0] KIND_QUOTED = 4'd4;
    localparam logic [3:0] KIND_SIMPLE = 4'd5;
    localparam logic [3:0] KIND_AND    = 4'd6;
    localparam logic [3:0] KIND_OR     = 4'd7;
    localparam logic [3:0] KIND_NOT    = 4'd8;

    localparam int MAX_RES   = 5;
    localparam int RES_IDX_W = 3;

    typedef struct packed {
        logic [3:0] kind;
        logic       has_char;
        logic [7:0] char_value;
        logic       token_done;
    } qtl_res_t;

    typedef struct packed {
        logic [RES_IDX_W-1:0]      count;
        qtl_res_t [MAX_RES-1:0]    res;
    } qtl_cmd_t;

    function automatic qtl_res_t mk_res(input logic [3:0] kind, input logic has_char,
                                        input logic [7:0] char_value, input logic done);
        qtl_res_t r;
        r.kind       = kind;
        r.has_char   = has_char;
        r.char_value = has_char ? char_value : 8'h00;
        r.token_done = done;
        return r;
    endfunction

endpackage

// ===== src/qtl_front.sv =====
`timescale 1ns / 1ps

module qtl_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [7:0]      in_char,
    input  logic            in_accept,
    output logic            wr_en,
    output qtl_pkg::qtl_cmd_t wr_cmd
);
    import qtl_pkg::*;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_QUOTED = 2'd1;
    localparam logic [1:0] MODE_SIMPLE = 2'd2;

    localparam logic [2:0] PFX_DEPTH = 3'd3;
    localparam logic [2:0] PFX_FLUSHED = 3'd4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VTAB  = 8'h0B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_D  = 8'h64;
    localparam logic [7:0] CH_LO_N  = 8'h6E;
    localparam logic [7:0] CH_LO_O  = 8'h6F;
    localparam logic [7:0] CH_LO_R  = 8'h72;
    localparam logic [7:0] CH_LO_T  = 8'h74;

    logic [1:0] mode_reg, mode_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [7:0] pfx_reg [3];
    logic [7:0] pfx_next [3];

    logic       is_blank, is_punct, is_term, run_idle;
    logic [7:0] f0, f1, f2;
    logic [3:0] kw_kind;
    logic       kw_hit;
    logic [RES_IDX_W-1:0] n;
    qtl_res_t [MAX_RES-1:0] res;

    function automatic logic [7:0] fold(input logic [7:0] c);
        return (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'd32 : c;
    endfunction

    always_comb begin
        is_blank = (in_char == CH_SPACE) || (in_char == CH_TAB) || (in_char == CH_VTAB);
        is_punct = (in_char == CH_COLON) || (in_char == CH_OPEN) || (in_char == CH_CLOSE);
        is_term  = (in_char == CH_NUL) || is_blank || is_punct;
        f0 = fold(pfx_reg[0]);
        f1 = fold(pfx_reg[1]);
        f2 = fold(pfx_reg[2]);
        kw_hit  = 1'b1;
        kw_kind = KIND_OR;
        if (cnt_reg == 3'd2 && f0 == CH_LO_O && f1 == CH_LO_R) begin
            kw_kind = KIND_OR;
        end else if (cnt_reg == PFX_DEPTH && f0 == CH_LO_A && f1 == CH_LO_N && f2 == CH_LO_D) begin
            kw_kind = KIND_AND;
        end else if (cnt_reg == PFX_DEPTH && f0 == CH_LO_N && f1 == CH_LO_O && f2 == CH_LO_T) begin
            kw_kind = KIND_NOT;
        end else begin
            kw_hit = 1'b0;
        end
    end

    always_comb begin
        res       = '0;
        n         = '0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        pfx_next  = pfx_reg;
        run_idle  = 1'b0;
        case (mode_reg)
            MODE_QUOTED: begin
                if (in_char == CH_QUOTE || in_char == CH_NUL) begin
                    res[0]    = mk_res(KIND_QUOTED, 1'b0, 8'h00, 1'b1);
                    n         = 3'd1;
                    mode_next = MODE_IDLE;
                    if (in_char == CH_NUL) begin
                        res[1] = mk_res(KIND_END, 1'b0, 8'h00, 1'b1);
                        n      = 3'd2;
                    end
                end else begin
                    res[0] = mk_res(KIND_QUOTED, 1'b1, in_char, 1'b0);
                    n      = 3'd1;
                end
            end
            MODE_SIMPLE: begin
                if (is_term) begin
                    if (kw_hit) begin
                        res[0] = mk_res(kw_kind, 1'b0, 8'h00, 1'b1);
                        n      = 3'd1;
                    end else begin
                        if (cnt_reg <= PFX_DEPTH) begin
                            for (int i = 0; i < 3; i++) begin
                                if (3'(i) < cnt_reg) begin
                                    res[n] = mk_res(KIND_SIMPLE, 1'b1, pfx_reg[i], 1'b0);
                                    n      = n + 3'd1;
                                end
                            end
                        end
                        res[n] = mk_res(KIND_SIMPLE, 1'b0, 8'h00, 1'b1);
                        n      = n + 3'd1;
                    end
                    mode_next = MODE_IDLE;
                    cnt_next  = '0;
                    run_idle  = 1'b1;
                end else if (cnt_reg < PFX_DEPTH) begin
                    pfx_next[cnt_reg[1:0]] = in_char;
                    cnt_next               = cnt_reg + 3'd1;
                end else if (cnt_reg == PFX_DEPTH) begin
                    for (int i = 0; i < 3; i++) begin
                        res[i] = mk_res(KIND_SIMPLE, 1'b1, pfx_reg[i], 1'b0);
                    end
                    res[3]   = mk_res(KIND_SIMPLE, 1'b1, in_char, 1'b0);
                    n        = 3'd4;
                    cnt_next = PFX_FLUSHED;
                end else begin
                    res[0] = mk_res(KIND_SIMPLE, 1'b1, in_char, 1'b0);
                    n      = 3'd1;
                end
            end
            default: begin
                mode_next = MODE_IDLE;
                run_idle  = 1'b1;
            end
        endcase

        if (run_idle && !is_blank) begin
            case (in_char)
                CH_NUL: begin
                    res[n] = mk_res(KIND_END, 1'b0, 8'h00, 1'b1);
                    n      = n + 3'd1;
                end
                CH_COLON: begin
                    res[n] = mk_res(KIND_COLON, 1'b0, 8'h00, 1'b1);
                    n      = n + 3'd1;
                end
                CH_OPEN: begin
                    res[n] = mk_res(KIND_OPEN, 1'b0, 8'h00, 1'b1);
                    n      = n + 3'd1;
                end
                CH_CLOSE: begin
                    res[n] = mk_res(KIND_CLOSE, 1'b0, 8'h00, 1'b1);
                    n      = n + 3'd1;
                end
                CH_QUOTE: begin
                    mode_next = MODE_QUOTED;
                end
                default: begin
                    mode_next   = MODE_SIMPLE;
                    pfx_next[0] = in_char;
                    cnt_next    = 3'd1;
                end
            endcase
        end
    end

    assign wr_en        = in_accept && (n != '0);
    assign wr_cmd.count = n;
    assign wr_cmd.res   = res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            cnt_reg  <= '0;
        end else if (in_accept) begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            pfx_reg <= pfx_next;
        end
    end

endmodule

// ===== src/qtl_fifo.sv =====
`timescale 1ns / 1ps

module qtl_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  qtl_pkg::qtl_cmd_t wr_cmd,
    output logic              full,
    input  logic              rd_en,
    output logic              rd_valid,
    output qtl_pkg::qtl_cmd_t rd_cmd
);
    import qtl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    qtl_cmd_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full     = (count_reg == CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en) begin
                count_reg <= count_reg + 1'b1;
            end else if (rd_en && !wr_en) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && full && !rd_en))
        else $error("queue write while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_en && !rd_valid))
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && !rd_en) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on write");
`endif

endmodule

// ===== src/qtl_back.sv =====
`timescale 1ns / 1ps

module qtl_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  qtl_pkg::qtl_cmd_t q_cmd,
    output logic              q_pop,
    output logic [7:0]        m_tdata,   // char_value
    output logic [5:0]        m_tuser,   // token_kind[3:0], has_char[4], token_done[5]
    output logic              m_tlast,   // last result of the input byte
    output logic              m_tvalid,
    input  logic              m_tready
);
    import qtl_pkg::*;

    logic [RES_IDX_W-1:0] idx_reg;
    logic                 valid_reg;
    logic [7:0]           data_reg;
    logic [5:0]           user_reg;
    logic                 last_reg;
    logic                 load, is_end;
    qtl_res_t             cur;

    assign load   = !valid_reg || m_tready;
    assign cur    = q_cmd.res[idx_reg];
    assign is_end = (idx_reg == q_cmd.count - 1'b1);
    assign q_pop  = load && q_valid && is_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= q_valid;
            if (q_valid) begin
                idx_reg <= is_end ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && q_valid) begin
            data_reg <= cur.char_value;
            user_reg <= {cur.token_done, cur.has_char, cur.kind};
            last_reg <= is_end;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== src/query_token_lexer.sv =====
`timescale 1ns / 1ps
// An accepted byte's results are written into the command queue, then into the output register.
// Throughput: one byte per cycle while the queue is not full (s_tready high).
// The command queue holds FIFO_DEPTH commands, each of up to five results of one byte.
// The single output register sets the rate: one result per cycle while m_tready is high.
// Reset: synchronous, active low; lexer idle, held count zero, queue and output empty.

module query_token_lexer #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_tdata,    // in_char
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic [7:0] m_tdata,    // char_value
    output logic [5:0] m_tuser,    // token_kind[3:0], has_char[4], token_done[5]
    output logic       m_tlast,    // last
    output logic       m_tvalid,
    input  logic       m_tready
);
    import qtl_pkg::*;

    logic     q_full, q_wr, q_valid, q_pop;
    qtl_cmd_t q_wr_cmd, q_rd_cmd;

    assign s_tready = !q_full;

    qtl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_char   (s_tdata),
        .in_accept (s_tvalid && s_tready),
        .wr_en     (q_wr),
        .wr_cmd    (q_wr_cmd)
    );

    qtl_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_wr),
        .wr_cmd   (q_wr_cmd),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_cmd   (q_rd_cmd)
    );

    qtl_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_rd_cmd),
        .q_pop    (q_pop),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

endmodule
